FILE: src/observation_hash_chain_compare_assert.svh
// assertion macros used by the block's top module
`ifndef OBSERVATION_HASH_CHAIN_COMPARE_ASSERT_SVH
`define OBSERVATION_HASH_CHAIN_COMPARE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define OHCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define OHCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ohcc_pkg.sv
`default_nettype none

package ohcc_pkg;

  // counter width of each run
  localparam int CountWidth = 32;
  typedef logic [CountWidth-1:0] count_t;
  localparam count_t CountMax = {CountWidth{1'b1}};

  // stream payload widths
  localparam int InDataWidth  = 72;
  localparam int InUserWidth  = 3;
  localparam int OutDataWidth = 104;

  // item commands
  localparam logic [1:0] CMD_COND  = 2'd0;
  localparam logic [1:0] CMD_ADDR  = 2'd1;
  localparam logic [1:0] CMD_CMP   = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  // hash primes
  localparam logic [63:0] XP1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] XP2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] XP3 = 64'h165667B19E3779F9;
  localparam logic [63:0] XP4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] XP5 = 64'h27D4EB2F165667C5;

  // hashed lengths in bytes
  localparam logic [63:0] LenAddr = 64'd16;
  localparam logic [63:0] LenCond = 64'd9;

  // datapath steps that load the multiplier
  typedef enum logic [2:0] {
    OP_NONE,
    OP_K1,
    OP_KR,
    OP_HR,
    OP_K2,
    OP_BYTE,
    OP_AV1,
    OP_AV2
  } op_e;

  // controller to datapath command group
  typedef struct packed {
    logic latch;
    logic start;
    op_e  op;
    logic fin;
    logic clear;
    logic emit;
  } dp_cmd_t;

  // rotate left by a constant amount
  function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
    return (x << r) | (x >> (64 - r));
  endfunction

endpackage

`default_nettype wire

FILE: src/observation_hash_chain_compare.sv
// address record: hashes the run digest and the address, then updates that run's digest and count
// condition record: hashes the run digest and the condition bit, then updates that run
// compare or disabled record: result only; clear: zeroes both runs, then gives a result
// each hash multiply runs on the single shared 32 x 32 multiplier
// async active-low reset zeroes both digests, both counts and the enable
`default_nettype none

`include "observation_hash_chain_compare_assert.svh"

module observation_hash_chain_compare import ohcc_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic                    cfg_wdata_i,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  // cond_bit [0], address [64:1], zero [71:65]
  input  wire logic [InDataWidth-1:0]  s_axis_tdata,
  // command [1:0], run_id [2]
  input  wire logic [InUserWidth-1:0]  s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // digest_out [63:0], count_out [95:64], mismatch [96], zero [103:97]
  output logic      [OutDataWidth-1:0] m_axis_tdata
);

  dp_cmd_t dp_cmd;
  logic    mul_done;

  ohcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_cmd_i    (s_axis_tuser[1:0]),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .mul_done_i  (mul_done),
    .cmd_o       (dp_cmd)
  );

  ohcc_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .mul_done_o (mul_done),
    .out_data_o (m_axis_tdata)
  );

  // checks on sequencing
  `OHCC_ASSERT_IMP(a_idle_no_mul, s_axis_tready, !mul_done, "multiplier busy while idle")
  `OHCC_ASSERT_IMP(a_emit_free, dp_cmd.emit, !m_axis_tvalid || m_axis_tready, "result overwritten")
  `OHCC_ASSERT_NXT(a_accept_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")

endmodule

`default_nettype wire

FILE: src/ohcc_mul.sv
`default_nettype none

// 64 x 64 low-half multiply on one 32 x 32 multiplier, in phases low, cross A and cross B
module ohcc_mul import ohcc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic      [63:0] prod_o,
  output logic             done_o
);

  localparam logic [1:0] PhLo     = 2'd0;
  localparam logic [1:0] PhCrossA = 2'd1;
  localparam logic [1:0] PhCrossB = 2'd2;

  logic        busy_q, busy_d;
  logic [1:0]  phase_q, phase_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] op_a, op_b;
  logic [63:0] mult;

  // operand select per phase
  always_comb begin
    op_a = (phase_q == PhCrossA) ? a_i[63:32] : a_i[31:0];
    op_b = (phase_q == PhCrossB) ? b_i[63:32] : b_i[31:0];
    mult = {32'd0, op_a} * {32'd0, op_b};
  end

  // accumulate partial products
  always_comb begin
    acc_d   = acc_q;
    busy_d  = busy_q;
    phase_d = phase_q;
    if (busy_q) begin
      if (phase_q == PhLo) begin
        acc_d = mult;
      end else begin
        acc_d = {acc_q[63:32] + mult[31:0], acc_q[31:0]};
      end
      phase_d = phase_q + 2'd1;
      if (phase_q == PhCrossB) begin
        busy_d = 1'b0;
      end
    end
    if (start_i) begin
      busy_d  = 1'b1;
      phase_d = PhLo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= PhLo;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign prod_o = acc_q;
  assign done_o = busy_q && (phase_q == PhCrossB);

endmodule

`default_nettype wire

FILE: src/ohcc_datapath.sv
`default_nettype none

// run state, hash registers and result register
module ohcc_datapath import ohcc_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire dp_cmd_t                 cmd_i,
  input  wire logic [InDataWidth-1:0]  in_data_i,
  input  wire logic [InUserWidth-1:0]  in_user_i,
  output logic                         mul_done_o,
  output logic      [OutDataWidth-1:0] out_data_o
);

  logic [63:0] run_digest_q [2];
  count_t      run_count_q  [2];

  logic [1:0]  cmd_q;
  logic        run_q;
  logic        cond_q;
  logic [63:0] addr_q;

  logic [63:0] h_q, h_d;
  logic [63:0] x_q, x_d;
  logic [63:0] c_q, c_d;
  logic [63:0] prod;
  logic [63:0] v;

  logic [63:0] dig_out_q;
  logic [31:0] cnt_out_q;
  logic        mis_q;
  logic        mismatch;

  ohcc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start),
    .a_i     (x_q),
    .b_i     (c_q),
    .prod_o  (prod),
    .done_o  (mul_done_o)
  );

  // next multiplier operand per step
  always_comb begin
    h_d = h_q;
    x_d = x_q;
    c_d = c_q;
    v   = prod;
    case (cmd_i.op)
      OP_K1: begin
        h_d = XP5 + ((cmd_q == CMD_ADDR) ? LenAddr : LenCond);
        x_d = run_digest_q[run_q];
        c_d = XP2;
      end
      OP_KR: begin
        x_d = rotl64(prod, 31);
        c_d = XP1;
      end
      OP_HR: begin
        x_d = rotl64(h_q ^ prod, 27);
        c_d = XP1;
      end
      OP_K2: begin
        h_d = prod + XP4;
        x_d = addr_q;
        c_d = XP2;
      end
      OP_BYTE: begin
        v   = (prod + XP4) ^ (cond_q ? XP5 : 64'd0);
        x_d = rotl64(v, 11);
        c_d = XP1;
      end
      OP_AV1: begin
        v   = (cmd_q == CMD_ADDR) ? prod + XP4 : prod;
        x_d = v ^ (v >> 33);
        c_d = XP2;
      end
      OP_AV2: begin
        x_d = prod ^ (prod >> 29);
        c_d = XP3;
      end
      default: begin
        x_d = x_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
    x_q <= x_d;
    c_q <= c_d;
  end

  // item fields held for the whole transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q  <= in_user_i[1:0];
      run_q  <= in_user_i[2];
      cond_q <= in_data_i[0];
      addr_q <= in_data_i[64:1];
    end
  end

  // run digests and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_digest_q[0] <= '0;
      run_digest_q[1] <= '0;
      run_count_q[0]  <= '0;
      run_count_q[1]  <= '0;
    end else if (cmd_i.clear) begin
      run_digest_q[0] <= '0;
      run_digest_q[1] <= '0;
      run_count_q[0]  <= '0;
      run_count_q[1]  <= '0;
    end else if (cmd_i.fin) begin
      run_digest_q[run_q] <= prod ^ (prod >> 32);
      if (run_count_q[run_q] != CountMax) begin
        run_count_q[run_q] <= run_count_q[run_q] + count_t'(1);
      end
    end
  end

  // run comparison
  assign mismatch = (cmd_q == CMD_CMP) &&
                    ((run_count_q[0] != run_count_q[1]) ||
                     (run_digest_q[0] != run_digest_q[1]));

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      dig_out_q <= run_digest_q[run_q];
      cnt_out_q <= 32'(run_count_q[run_q]);
      mis_q     <= mismatch;
    end
  end

  assign out_data_o = {7'd0, mis_q, cnt_out_q, dig_out_q};

endmodule

`default_nettype wire

FILE: src/ohcc_ctrl.sv
`default_nettype none

// step sequencer and stream handshakes
module ohcc_ctrl import ohcc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] in_cmd_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire logic       mul_done_i,
  output dp_cmd_t         cmd_o
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_K1   = 4'd1;
  localparam logic [3:0] ST_KR   = 4'd2;
  localparam logic [3:0] ST_HR   = 4'd3;
  localparam logic [3:0] ST_K2   = 4'd4;
  localparam logic [3:0] ST_BYTE = 4'd5;
  localparam logic [3:0] ST_AV1  = 4'd6;
  localparam logic [3:0] ST_AV2  = 4'd7;
  localparam logic [3:0] ST_WAIT = 4'd8;
  localparam logic [3:0] ST_FIN  = 4'd9;
  localparam logic [3:0] ST_CLR  = 4'd10;
  localparam logic [3:0] ST_DONE = 4'd11;

  logic [3:0] state_q, state_d;
  logic [3:0] ret_q, ret_d;
  logic       round2_q, round2_d;
  logic       is_addr_q, is_addr_d;
  logic       out_valid_q, out_valid_d;
  logic       observe_en_q;

  // enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      observe_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      observe_en_q <= cfg_wdata_i;
    end
  end

  // sequencing
  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    round2_d   = round2_q;
    is_addr_d  = is_addr_q;
    cmd_o      = '0;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          is_addr_d   = (in_cmd_i == CMD_ADDR);
          round2_d    = 1'b0;
          case (in_cmd_i)
            CMD_CLEAR: state_d = ST_CLR;
            CMD_CMP:   state_d = ST_DONE;
            default:   state_d = observe_en_q ? ST_K1 : ST_DONE;
          endcase
        end
      end
      ST_K1: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = OP_K1;
        ret_d       = ST_KR;
        state_d     = ST_WAIT;
      end
      ST_KR: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = OP_KR;
        ret_d       = ST_HR;
        state_d     = ST_WAIT;
      end
      ST_HR: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = OP_HR;
        ret_d       = !is_addr_q ? ST_BYTE : (round2_q ? ST_AV1 : ST_K2);
        state_d     = ST_WAIT;
      end
      ST_K2: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = OP_K2;
        round2_d    = 1'b1;
        ret_d       = ST_KR;
        state_d     = ST_WAIT;
      end
      ST_BYTE: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = OP_BYTE;
        ret_d       = ST_AV1;
        state_d     = ST_WAIT;
      end
      ST_AV1: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = OP_AV1;
        ret_d       = ST_AV2;
        state_d     = ST_WAIT;
      end
      ST_AV2: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = OP_AV2;
        ret_d       = ST_FIN;
        state_d     = ST_WAIT;
      end
      ST_WAIT: begin
        if (mul_done_i) begin
          state_d = ret_q;
        end
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_DONE;
      end
      ST_CLR: begin
        cmd_o.clear = 1'b1;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      round2_q    <= 1'b0;
      is_addr_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      round2_q    <= round2_d;
      is_addr_q   <= is_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
